>>> sv/slot_pool_free_active_lists_macros.svh
// Assertion macros for the slot pool.
`ifndef SLOT_POOL_FREE_ACTIVE_LISTS_MACROS_SVH
`define SLOT_POOL_FREE_ACTIVE_LISTS_MACROS_SVH

`ifndef SYNTHESIS
`define SPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slot pool assertion failed");
`define SPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot pool assertion failed");
`else
`define SPF_ASSERT(lbl, prop)
`define SPF_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

>>> sv/spfal_pkg.sv
package spfal_pkg;

  localparam int unsigned SLOTS  = 512;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  typedef logic [SLOT_W-1:0] slot_t;

  // One access slot of a link memory: a write port and a read port.
  typedef struct packed {
    logic  we;
    slot_t waddr;
    slot_t wdata;
    slot_t raddr;
  } ram_req_t;

endpackage

>>> sv/spfal_ram.sv
module spfal_ram (
  input  logic               clk_i,
  input  spfal_pkg::ram_req_t req_i,
  output spfal_pkg::slot_t   rdata_o
);
  import spfal_pkg::*;

  slot_t mem [SLOTS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/slot_pool_free_active_lists.sv
// Channel  | valid       | stall       | payload
// ---------+-------------+-------------+------------------------------------------
// in       | in_valid_i  | in_stall_o  | command_i, slot_i
// out      | out_valid_o | out_stall_i | ok_o, result_slot_o, cursor_valid_o,
//          |             |             | cursor_slot_o
//
// One item at a time. Allocate unlinks the free head, links it into the active ring
// (ST_INS1, ST_INS2) and loads the output register. Release first walks the active ring
// until the slot is met, a miss walking the whole ring; a refusal on an empty ring or pool
// goes straight to the output register. After reset a clearing pass builds the free ring;
// in_stall_o is high during it. A result waiting in the output register does not block
// accept; the following result holds in the sequencer until the output register frees up.
`include "slot_pool_free_active_lists_macros.svh"

module slot_pool_free_active_lists (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  spfal_pkg::slot_t slot_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             ok_o,
  output spfal_pkg::slot_t result_slot_o,
  output logic             cursor_valid_o,
  output spfal_pkg::slot_t cursor_slot_o
);
  import spfal_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_UNLINK = 3'd3;
  localparam logic [2:0] ST_INS1   = 3'd4;
  localparam logic [2:0] ST_INS2   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam slot_t LAST = SLOT_W'(SLOTS - 1);

  logic [2:0] state_q, state_d;
  slot_t      clr_q, clr_d;
  logic       op_q, op_d;
  slot_t      n_q, n_d;
  slot_t      want_q, want_d;
  slot_t      p_q, p_d;
  logic       ok_q, ok_d;
  slot_t      free_head_q, free_head_d;
  logic       free_ne_q, free_ne_d;
  slot_t      act_head_q, act_head_d;
  logic       act_ne_q, act_ne_d;
  slot_t      cursor_q, cursor_d;
  logic       cur_set_q, cur_set_d;

  logic  out_valid_q, out_valid_d;
  logic  out_ok_q, out_ok_d;
  slot_t out_slot_q, out_slot_d;
  logic  out_cv_q, out_cv_d;
  slot_t out_cs_q, out_cs_d;

  ram_req_t nreq, preq;
  slot_t    nrd, prd;

  spfal_ram u_next (.clk_i(clk_i), .req_i(nreq), .rdata_o(nrd));
  spfal_ram u_prev (.clk_i(clk_i), .req_i(preq), .rdata_o(prd));

  logic  in_acc;
  slot_t src_head, dst_head;
  logic  dst_ne;
  logic  single;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Source ring loses the slot, destination ring gains it.
  assign src_head = op_q ? act_head_q : free_head_q;
  assign dst_head = op_q ? free_head_q : act_head_q;
  assign dst_ne   = op_q ? free_ne_q : act_ne_q;
  assign single   = (src_head == n_q) && (nrd == n_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    n_d         = n_q;
    want_d      = want_q;
    p_d         = p_q;
    ok_d        = ok_q;
    free_head_d = free_head_q;
    free_ne_d   = free_ne_q;
    act_head_d  = act_head_q;
    act_ne_d    = act_ne_q;
    cursor_d    = cursor_q;
    cur_set_d   = cur_set_q;
    out_ok_d    = out_ok_q;
    out_slot_d  = out_slot_q;
    out_cv_d    = out_cv_q;
    out_cs_d    = out_cs_q;
    out_valid_d = out_valid_q && out_stall_i;

    nreq = '{we: 1'b0, waddr: n_q, wdata: n_q, raddr: n_q};
    preq = '{we: 1'b0, waddr: n_q, wdata: n_q, raddr: n_q};

    case (state_q)
      ST_INIT: begin
        // Build the reset free ring: next points down, prev points up.
        nreq.we    = 1'b1;
        nreq.waddr = clr_q;
        nreq.wdata = (clr_q == '0) ? LAST : clr_q - 1'b1;
        preq.we    = 1'b1;
        preq.waddr = clr_q;
        preq.wdata = (clr_q == LAST) ? '0 : clr_q + 1'b1;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d   = command_i;
          want_d = slot_i;
          ok_d   = 1'b0;
          if (command_i == CMD_ALLOC) begin
            if (free_ne_q) begin
              n_d        = free_head_q;
              nreq.raddr = free_head_q;
              preq.raddr = free_head_q;
              state_d    = ST_UNLINK;
            end else begin
              state_d = ST_DONE;
            end
          end else if (act_ne_q) begin
            if (act_head_q == slot_i) begin
              n_d        = act_head_q;
              nreq.raddr = act_head_q;
              preq.raddr = act_head_q;
              state_d    = ST_UNLINK;
            end else begin
              nreq.raddr = act_head_q;
              state_d    = ST_WALK;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        // nrd is the successor of the last entry looked at.
        if (nrd == act_head_q) begin
          state_d = ST_DONE;
        end else if (nrd == want_q) begin
          n_d        = nrd;
          nreq.raddr = nrd;
          preq.raddr = nrd;
          state_d    = ST_UNLINK;
        end else begin
          nreq.raddr = nrd;
        end
      end
      ST_UNLINK: begin
        // nrd = next[n], prd = prev[n]
        if (!single) begin
          preq.we    = 1'b1;
          preq.waddr = nrd;
          preq.wdata = prd;
          nreq.we    = 1'b1;
          nreq.waddr = prd;
          nreq.wdata = nrd;
        end
        preq.raddr = dst_head;
        if (op_q == CMD_RELEASE) begin
          if (single) begin
            act_ne_d = 1'b0;
          end else if (act_head_q == n_q) begin
            act_head_d = nrd;
          end
          if (cur_set_q && cursor_q == n_q) begin
            if (nrd == n_q) begin
              cur_set_d = 1'b0;
            end else begin
              cursor_d = nrd;
            end
          end
        end else begin
          if (single) begin
            free_ne_d = 1'b0;
          end else begin
            free_head_d = nrd;
          end
        end
        state_d = ST_INS1;
      end
      ST_INS1: begin
        p_d        = prd;
        preq.we    = 1'b1;
        preq.waddr = n_q;
        preq.wdata = dst_ne ? prd : n_q;
        nreq.we    = 1'b1;
        nreq.waddr = n_q;
        nreq.wdata = dst_ne ? dst_head : n_q;
        state_d    = ST_INS2;
      end
      ST_INS2: begin
        if (dst_ne) begin
          preq.we    = 1'b1;
          preq.waddr = dst_head;
          preq.wdata = n_q;
          nreq.we    = 1'b1;
          nreq.waddr = p_q;
          nreq.wdata = n_q;
        end
        if (op_q == CMD_RELEASE) begin
          free_head_d = n_q;
          free_ne_d   = 1'b1;
        end else begin
          act_head_d = n_q;
          act_ne_d   = 1'b1;
          if (!cur_set_q) begin
            cursor_d  = n_q;
            cur_set_d = 1'b1;
          end
        end
        ok_d    = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = ok_q;
          out_slot_d  = ok_q ? n_q : '0;
          out_cv_d    = cur_set_q;
          out_cs_d    = cur_set_q ? cursor_q : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      op_q        <= CMD_ALLOC;
      ok_q        <= 1'b0;
      free_head_q <= LAST;
      free_ne_q   <= 1'b1;
      act_head_q  <= '0;
      act_ne_q    <= 1'b0;
      cursor_q    <= '0;
      cur_set_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      op_q        <= op_d;
      ok_q        <= ok_d;
      free_head_q <= free_head_d;
      free_ne_q   <= free_ne_d;
      act_head_q  <= act_head_d;
      act_ne_q    <= act_ne_d;
      cursor_q    <= cursor_d;
      cur_set_q   <= cur_set_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    want_q     <= want_d;
    p_q        <= p_d;
    out_ok_q   <= out_ok_d;
    out_slot_q <= out_slot_d;
    out_cv_q   <= out_cv_d;
    out_cs_q   <= out_cs_d;
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign result_slot_o  = out_slot_q;
  assign cursor_valid_o = out_cv_q;
  assign cursor_slot_o  = out_cs_q;

  `SPF_ASSERT(a_some_ring_nonempty, free_ne_q || act_ne_q)
  `SPF_ASSERT_IMPL(a_busy_after_accept, in_acc, ##1 in_stall_o)
  `SPF_ASSERT_IMPL(a_fail_zero_slot, out_valid_o && !ok_o, result_slot_o == '0)
  `SPF_ASSERT_IMPL(a_cursor_needs_active, cur_set_q && state_q == ST_IDLE, act_ne_q)

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spfal_pkg::*;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } pool_op_e;

  typedef struct packed {
    logic  ok;
    slot_t slot;
    logic  cur_valid;
    slot_t cur_slot;
  } pool_reply_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  logic  command_i = 1'b0;
  slot_t slot_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  logic  ok_o;
  slot_t result_slot_o;
  logic  cursor_valid_o;
  slot_t cursor_slot_o;

  slot_pool_free_active_lists dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .slot_i         (slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .result_slot_o  (result_slot_o),
    .cursor_valid_o (cursor_valid_o),
    .cursor_slot_o  (cursor_slot_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the pool: both rings share one pair of link arrays.
  slot_t       nxt_q [SLOTS];
  slot_t       prv_q [SLOTS];
  bit          is_active [SLOTS];
  slot_t       free_head_q;
  logic        free_any_q;
  slot_t       active_head_q;
  logic        active_any_q;
  slot_t       cursor_q;
  logic        cursor_on_q;
  int unsigned active_count;

  pool_reply_t pool_replies_q[$];
  int unsigned fail_count;
  int unsigned n_alloc, n_release, n_refused, n_exhausted;
  bit          quiet;

  function automatic void reset_pool_model();
    for (int i = 0; i < SLOTS; i++) begin
      nxt_q[i]     = slot_t'((i + SLOTS - 1) % SLOTS);
      prv_q[i]     = slot_t'((i + 1) % SLOTS);
      is_active[i] = 1'b0;
    end
    free_head_q   = slot_t'(SLOTS - 1);
    free_any_q    = 1'b1;
    active_head_q = '0;
    active_any_q  = 1'b0;
    cursor_q      = '0;
    cursor_on_q   = 1'b0;
    active_count  = 0;
  endfunction

  // Insert n just ahead of the head and make it the new head.
  function automatic void link_in(inout slot_t head, inout logic any, input slot_t n);
    slot_t p;
    if (any) begin
      p        = prv_q[head];
      prv_q[n] = p;
      nxt_q[n] = head;
      prv_q[head] = n;
      nxt_q[p] = n;
    end else begin
      prv_q[n] = n;
      nxt_q[n] = n;
    end
    head = n;
    any  = 1'b1;
  endfunction

  function automatic void link_out(inout slot_t head, inout logic any, input slot_t n);
    slot_t nx, pv;
    nx = nxt_q[n];
    pv = prv_q[n];
    if (head == n && nx == n) begin
      any = 1'b0;
    end else begin
      prv_q[nx] = pv;
      nxt_q[pv] = nx;
      if (head == n) head = nx;
    end
  endfunction

  function automatic pool_reply_t apply_pool_op(input pool_op_e op, input slot_t want);
    pool_reply_t r;
    slot_t       e;
    r = '0;
    if (op == OP_ALLOC) begin
      if (free_any_q) begin
        e = free_head_q;
        link_out(free_head_q, free_any_q, e);
        link_in(active_head_q, active_any_q, e);
        is_active[e] = 1'b1;
        active_count++;
        if (!cursor_on_q) begin
          cursor_q    = e;
          cursor_on_q = 1'b1;
        end
        r.ok   = 1'b1;
        r.slot = e;
      end
    end else if (active_any_q && is_active[want]) begin
      e = want;
      // The cursor steps to the successor, or drops when the ring empties.
      if (cursor_on_q && cursor_q == e) begin
        if (nxt_q[e] == e) cursor_on_q = 1'b0;
        else cursor_q = nxt_q[e];
      end
      link_out(active_head_q, active_any_q, e);
      link_in(free_head_q, free_any_q, e);
      is_active[e] = 1'b0;
      active_count--;
      r.ok   = 1'b1;
      r.slot = e;
    end
    r.cur_valid = cursor_on_q;
    r.cur_slot  = cursor_on_q ? cursor_q : '0;
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    if (quiet || $urandom_range(0, 99) >= 28) return 0;
    return $urandom_range(1, 12);
  endfunction

  function automatic slot_t pick_active();
    slot_t       e;
    int unsigned k;
    if (cursor_on_q && $urandom_range(0, 99) < 20) return cursor_q;
    e = active_head_q;
    k = $urandom_range(0, active_count - 1);
    repeat (k) e = nxt_q[e];
    return e;
  endfunction

  function automatic slot_t any_slot();
    return slot_t'($urandom_range(0, SLOTS - 1));
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken,
  // leaving valid high so the next item can follow without a bubble.
  task automatic send_op(input pool_op_e op, input slot_t s);
    int unsigned gap;
    pool_reply_t r;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= op;
    slot_i     <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_ALLOC) n_alloc++;
    else n_release++;
    if (op == OP_ALLOC && !free_any_q) n_exhausted++;
    r = apply_pool_op(op, s);
    if (!r.ok) n_refused++;
    pool_replies_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 28);
  end

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_replies
    pool_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pool_replies_q.size() == 0) begin
        $display("%0t: unexpected item ok=%0b slot=%0d cursor=%0b/%0d", $time,
                 ok_o, result_slot_o, cursor_valid_o, cursor_slot_o);
        fail_count++;
      end else begin
        want = pool_replies_q.pop_front();
        report_field("ok", want.ok, ok_o);
        report_field("result_slot", want.slot, result_slot_o);
        report_field("cursor_valid", want.cur_valid, cursor_valid_o);
        report_field("cursor_slot", want.cur_slot, cursor_slot_o);
      end
    end
  end

  task automatic test_release_on_idle_pool();
    send_op(OP_RELEASE, '0);
    send_op(OP_RELEASE, slot_t'(SLOTS - 1));
    send_op(OP_RELEASE, 9'h155);
  endtask

  task automatic test_single_slot();
    send_op(OP_ALLOC, 9'h1FF);
    send_op(OP_RELEASE, slot_t'(SLOTS - 1));
    send_op(OP_ALLOC, '0);
    send_op(OP_RELEASE, '0);
  endtask

  // Walk the cursor through middle, head and lone-slot releases.
  task automatic test_cursor_handoff();
    send_op(OP_ALLOC, 9'h0AA);
    send_op(OP_ALLOC, '0);
    send_op(OP_ALLOC, '0);
    send_op(OP_RELEASE, slot_t'(SLOTS - 1));
    send_op(OP_RELEASE, slot_t'(SLOTS - 3));
    send_op(OP_RELEASE, slot_t'(SLOTS - 3));
    send_op(OP_RELEASE, active_head_q);
    send_op(OP_RELEASE, active_head_q);
    send_op(OP_RELEASE, 9'h0AA);
    send_op(OP_ALLOC, '0);
    send_op(OP_ALLOC, '0);
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      quiet = (i < 80);
      roll  = $urandom_range(0, 99);
      if (roll < 55) send_op(OP_ALLOC, any_slot());
      else if (roll < 90 && active_count > 0) send_op(OP_RELEASE, pick_active());
      else send_op(OP_RELEASE, any_slot());
    end
    quiet = 1'b0;
  endtask

  task automatic test_exhaust_pool();
    while (free_any_q) begin
      if ($urandom_range(0, 99) < 8) send_op(OP_RELEASE, any_slot());
      else send_op(OP_ALLOC, any_slot());
    end
    repeat (6) send_op(OP_ALLOC, any_slot());
  endtask

  task automatic test_random_drain(input int unsigned count);
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 85 && active_count > 0) send_op(OP_RELEASE, pick_active());
      else if (roll < 95) send_op(OP_RELEASE, any_slot());
      else send_op(OP_ALLOC, any_slot());
    end
  endtask

  task automatic wait_replies_done();
    int unsigned waited;
    waited = 0;
    while (pool_replies_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pool_replies_q.size() != 0) begin
      $display("%0t: %0d items never came back", $time, pool_replies_q.size());
      fail_count++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    fail_count = 0;
    quiet      = 1'b0;
    reset_pool_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_release_on_idle_pool();
    test_single_slot();
    test_cursor_handoff();
    test_random_mix(200);
    test_exhaust_pool();
    test_random_drain(220);
    in_valid_i <= 1'b0;
    wait_replies_done();
    $display("Sent %0d allocates and %0d releases, %0d refused.",
             n_alloc, n_release, n_refused);
    $display("Pool ran dry on %0d allocates; %0d slots active at the end.",
             n_exhausted, active_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timed out with %0d items outstanding", pool_replies_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
